/* design/assert_macros.svh */
// Assertion macros for the block cipher design.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/bc128_pkg.sv */
// Shared types, constants and functions for the AES-128 encryption pipeline.
// No dependencies.
package bc128_pkg;
  localparam int NumRounds = 10;
  localparam logic [7:0] Poly = 8'h1b;
  localparam logic [1:0] RegKeyUpper = 2'd0;
  localparam logic [1:0] RegKeyLower = 2'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? Poly : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction
endpackage

/* design/bc128_round_cell.sv */
// One round cell: advances block state and round key by one AES round.
// Depends on bc128_pkg.
module bc128_round_cell import bc128_pkg::*; #(
  parameter logic [7:0] Rcon = 8'h01,
  parameter bit Final = 1'b0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [127:0] in_state,
  input  logic [127:0] in_key,
  output logic         out_valid,
  output logic [127:0] out_state,
  output logic [127:0] out_key
);
  logic [7:0]   sb [16];
  logic [7:0]   mc [16];
  logic [127:0] key_next;
  logic [127:0] state_next;
  logic [31:0]  tw;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[4*c+r] = SBOX[in_state[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
      for (int r = 0; r < 4; r++) begin
        mc[4*c+r] = Final ? sb[4*c+r]
                  : sb[4*c+r] ^ all ^ xtime(sb[4*c+r] ^ sb[4*c+((r+1)%4)]);
      end
    end
    tw = sub_word({in_key[23:0], in_key[31:24]}) ^ {Rcon, 24'h0};
    key_next[127:96] = in_key[127:96] ^ tw;
    key_next[95:64]  = in_key[95:64] ^ key_next[127:96];
    key_next[63:32]  = in_key[63:32] ^ key_next[95:64];
    key_next[31:0]   = in_key[31:0] ^ key_next[63:32];
    for (int i = 0; i < 16; i++) begin
      state_next[127-8*i -: 8] = mc[i] ^ key_next[127-8*i -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_state <= state_next;
      out_key   <= key_next;
    end
  end
endmodule

/* design/block_cipher_128_encrypt.sv */
// Top level of the AES-128 encryption pipeline: ten chained round cells.
// Depends on bc128_pkg, bc128_round_cell and assert_macros.svh.
//
//  channel   | handshake             | payload
//  plain     | plain_valid/ready     | plain_upper, plain_lower
//  cipher    | cipher_valid/ready    | cipher_upper, cipher_lower
//  config    | cfg_valid/ready       | cfg_index, cfg_data
//
// One block is accepted per cycle while the chain is not stalled; the result
// passes through eleven register stages: input key add plus ten round cells.
// The whole chain stalls together when the result is not taken. Reset clears valid bits and the key to zero.
`include "assert_macros.svh"
module block_cipher_128_encrypt import bc128_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        plain_valid,
  output logic        plain_ready,
  input  logic [63:0] plain_upper,
  input  logic [63:0] plain_lower,
  output logic        cipher_valid,
  input  logic        cipher_ready,
  output logic [63:0] cipher_upper,
  output logic [63:0] cipher_lower,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [127:0] key;
  logic         en;
  logic         v   [NumRounds+1];
  logic [127:0] st  [NumRounds+1];
  logic [127:0] rk  [NumRounds+1];

  assign en          = !cipher_valid || cipher_ready;
  assign plain_ready = en;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key  <= '0;
      v[0] <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == RegKeyUpper) key[127:64] <= cfg_data;
      if (cfg_valid && cfg_index == RegKeyLower) key[63:0] <= cfg_data;
      if (en) v[0] <= plain_valid;
    end
    if (en) begin
      st[0] <= {plain_upper, plain_lower} ^ key;
      rk[0] <= key;
    end
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    bc128_round_cell #(.Rcon(RCON[g]), .Final(g == NumRounds - 1)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[g]), .in_state(st[g]), .in_key(rk[g]),
      .out_valid(v[g+1]), .out_state(st[g+1]), .out_key(rk[g+1])
    );
  end

  assign cipher_valid = v[NumRounds];
  assign cipher_upper = st[NumRounds][127:64];
  assign cipher_lower = st[NumRounds][63:0];

  `ASSERT_NEXT(a_stall_hold, cipher_valid && !cipher_ready, cipher_valid)
  `ASSERT_IMPL(a_ready_en, cipher_valid && !cipher_ready, !plain_ready)
  `ASSERT_NEXT(a_advance, plain_ready && v[NumRounds-1], cipher_valid)
endmodule
